@@ hdl/trpk_pkg.sv @@
// Package with shared types and constants for the pivot kinematics unit.
`timescale 1ns / 1ps
package trpk_pkg;

   // One full turn and one quarter turn in Q16.16 degrees.
   localparam logic [24:0] TURN_Q16    = 25'd23592960;
   localparam logic [22:0] QUARTER_Q16 = 23'd5898240;

   // CORDIC start value (gain compensation) in Q2.30.
   localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
   localparam logic signed [63:0] HALF_Q30 = 64'sd536870912;

   // Reset value of the pivot length, 250.0 mm.
   localparam logic [30:0] PIVOT_RESET = 31'd16384000;

   // Operation codes.
   localparam logic OP_FORWARD = 1'b0;
   localparam logic OP_INVERSE = 1'b1;

   // Payload that travels beside the CORDIC cells.
   typedef struct packed {
      logic              op;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic signed [31:0] a;
      logic signed [31:0] b;
      logic signed [31:0] c;
      logic signed [31:0] u;
      logic signed [31:0] v;
      logic signed [31:0] w;
      logic [1:0]        qb;
      logic [1:0]        qc;
   } side_type;

   // Arctangent of 2^-i in Q16.16 degrees.
   function automatic logic signed [23:0] arc_tab(input logic [5:0] i);
      logic signed [23:0] r;
      begin
         case (i)
            6'd0: r = 24'sd2949120;
            6'd1: r = 24'sd1740967;
            6'd2: r = 24'sd919879;
            6'd3: r = 24'sd466945;
            6'd4: r = 24'sd234379;
            6'd5: r = 24'sd117304;
            6'd6: r = 24'sd58666;
            6'd7: r = 24'sd29335;
            6'd8: r = 24'sd14668;
            6'd9: r = 24'sd7334;
            6'd10: r = 24'sd3667;
            6'd11: r = 24'sd1833;
            6'd12: r = 24'sd917;
            6'd13: r = 24'sd458;
            6'd14: r = 24'sd229;
            6'd15: r = 24'sd115;
            6'd16: r = 24'sd57;
            6'd17: r = 24'sd29;
            6'd18: r = 24'sd14;
            6'd19: r = 24'sd7;
            6'd20: r = 24'sd4;
            6'd21: r = 24'sd2;
            6'd22: r = 24'sd1;
            default: r = 24'sd0;
         endcase
         return r;
      end
   endfunction

endpackage

@@ hdl/tilt_rotary_pivot_kinematics_unit.sv @@
// Top level of the tilt and rotary spindle pivot kinematics unit.
`timescale 1ns / 1ps
// Converts one machine position per clock between joint and Cartesian space.
// busy is always low, so a request is taken on every cycle that start is high.
// Each request passes through the angle reduction, the CORDIC cells, four multiply
// and rounding stages and one sum/saturate stage before its result is
// registered; rsp_valid marks it for one cycle and cannot be held off. Write
// the pivot length through csr_we only when no request is in flight.
module tilt_rotary_pivot_kinematics_unit #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_operation,
   input  logic signed [31:0] req_lin_x,
   input  logic signed [31:0] req_lin_y,
   input  logic signed [31:0] req_lin_z,
   input  logic signed [31:0] req_rot_a,
   input  logic signed [31:0] req_tilt_b,
   input  logic signed [31:0] req_spin_c,
   input  logic signed [31:0] req_aux_u,
   input  logic signed [31:0] req_aux_v,
   input  logic signed [31:0] req_aux_w,
   input  logic               csr_we,
   input  logic [30:0]        csr_wdata,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_out_x,
   output logic signed [31:0] rsp_out_y,
   output logic signed [31:0] rsp_out_z,
   output logic signed [31:0] rsp_out_a,
   output logic signed [31:0] rsp_out_b,
   output logic signed [31:0] rsp_out_c,
   output logic signed [31:0] rsp_out_u,
   output logic signed [31:0] rsp_out_v,
   output logic signed [31:0] rsp_out_w
);
   localparam int N = CORDIC_STAGES;

   logic [30:0] len_ff;
   logic [1:0]  vld0_ff;
   trpk_pkg::side_type side0_ff, side1_ff, side_in;
   logic [1:0]  qb, qc;
   logic signed [24:0] rb, rc;

   assign busy = 1'b0;

   // Pivot length register.
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= trpk_pkg::PIVOT_RESET;
      end else if (csr_we) begin
         len_ff <= csr_wdata;
      end
   end

   trpk_reduce u_red_b (.clock(clock), .ang_i(req_tilt_b), .quad_o(qb), .rest_o(rb));
   trpk_reduce u_red_c (.clock(clock), .ang_i(req_spin_c), .quad_o(qc), .rest_o(rc));

   // Request payload is registered in step with the angle reduction.
   always_comb begin
      side_in    = '0;
      side_in.op = req_operation;
      side_in.x  = req_lin_x;
      side_in.y  = req_lin_y;
      side_in.z  = req_lin_z;
      side_in.a  = req_rot_a;
      side_in.b  = req_tilt_b;
      side_in.c  = req_spin_c;
      side_in.u  = req_aux_u;
      side_in.v  = req_aux_v;
      side_in.w  = req_aux_w;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld0_ff <= '0;
      end else begin
         vld0_ff <= {vld0_ff[0], start};
      end
      side0_ff <= side_in;
      side1_ff <= side0_ff;
   end

   // Chain of CORDIC cells.
   logic               vld   [N+1];
   logic signed [33:0] xb    [N+1];
   logic signed [33:0] yb    [N+1];
   logic signed [24:0] zb    [N+1];
   logic signed [33:0] xc    [N+1];
   logic signed [33:0] yc    [N+1];
   logic signed [24:0] zc    [N+1];
   trpk_pkg::side_type sd    [N+1];

   always_comb begin
      vld[0]   = vld0_ff[1];
      xb[0]    = trpk_pkg::GAIN_Q30;
      yb[0]    = '0;
      zb[0]    = rb;
      xc[0]    = trpk_pkg::GAIN_Q30;
      yc[0]    = '0;
      zc[0]    = rc;
      sd[0]    = side1_ff;
      sd[0].qb = qb;
      sd[0].qc = qc;
   end

   for (genvar g = 0; g < N; g++) begin : g_cell
      trpk_cell #(.STAGE(g)) u_cell (
         .clock(clock), .reset(reset), .vld_i(vld[g]),
         .xb_i(xb[g]), .yb_i(yb[g]), .zb_i(zb[g]),
         .xc_i(xc[g]), .yc_i(yc[g]), .zc_i(zc[g]), .side_i(sd[g]),
         .vld_o(vld[g+1]),
         .xb_o(xb[g+1]), .yb_o(yb[g+1]), .zb_o(zb[g+1]),
         .xc_o(xc[g+1]), .yc_o(yc[g+1]), .zc_o(zc[g+1]), .side_o(sd[g+1])
      );
   end

   // Quadrant mapping to sine and cosine.
   logic signed [33:0] sb_in, cb_in, sc_in, cc_in;
   always_comb begin
      case (sd[N].qb)
         2'd0: begin cb_in = xb[N];  sb_in = yb[N];  end
         2'd1: begin cb_in = -yb[N]; sb_in = xb[N];  end
         2'd2: begin cb_in = -xb[N]; sb_in = -yb[N]; end
         default: begin cb_in = yb[N]; sb_in = -xb[N]; end
      endcase
      case (sd[N].qc)
         2'd0: begin cc_in = xc[N];  sc_in = yc[N];  end
         2'd1: begin cc_in = -yc[N]; sc_in = xc[N];  end
         2'd2: begin cc_in = -xc[N]; sc_in = -yc[N]; end
         default: begin cc_in = yc[N]; sc_in = -xc[N]; end
      endcase
   end

   // Stage M1: L*sin(B) and L*cos(B).
   logic [3:0] vm_ff;
   logic signed [63:0] plsb_ff, plcb_ff;
   logic signed [33:0] sc1_ff, cc1_ff;
   trpk_pkg::side_type sm1_ff, sm2_ff, sm3_ff, sm4_ff;
   always_ff @(posedge clock) begin
      plsb_ff <= 64'($signed({1'b0, len_ff})) * 64'(sb_in);
      plcb_ff <= 64'($signed({1'b0, len_ff})) * 64'(cb_in);
      sc1_ff  <= sc_in;
      cc1_ff  <= cc_in;
      sm1_ff  <= sd[N];
   end

   // Stage M2: round to Q16.16.
   logic signed [63:0] lsb_ff, lcb_ff;
   logic signed [33:0] sc2_ff, cc2_ff;
   always_ff @(posedge clock) begin
      lsb_ff <= (plsb_ff + trpk_pkg::HALF_Q30) >>> 30;
      lcb_ff <= (plcb_ff + trpk_pkg::HALF_Q30) >>> 30;
      sc2_ff <= sc1_ff;
      cc2_ff <= cc1_ff;
      sm2_ff <= sm1_ff;
   end

   // Stage M3: second products and dz.
   logic signed [63:0] pdx_ff, pdy_ff, dz_ff;
   always_ff @(posedge clock) begin
      pdx_ff <= 64'($signed(lsb_ff[33:0])) * 64'(sc2_ff);
      pdy_ff <= 64'($signed(lsb_ff[33:0])) * 64'(cc2_ff);
      dz_ff  <= 64'($signed({1'b0, len_ff})) - lcb_ff;
      sm3_ff <= sm2_ff;
   end

   // Stage M4: round the offsets.
   logic signed [63:0] dx_ff, dy_ff, dz2_ff;
   always_ff @(posedge clock) begin
      dx_ff  <= -((pdx_ff + trpk_pkg::HALF_Q30) >>> 30);
      dy_ff  <= (pdy_ff + trpk_pkg::HALF_Q30) >>> 30;
      dz2_ff <= dz_ff;
      sm4_ff <= sm3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vm_ff <= '0;
      end else begin
         vm_ff <= {vm_ff[2:0], vld[N]};
      end
   end

   // Sum and saturate.
   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      begin
         if (v > 64'sd2147483647) r = 32'sh7FFF_FFFF;
         else if (v < -64'sd2147483648) r = 32'sh8000_0000;
         else r = v[31:0];
         return r;
      end
   endfunction

   logic signed [63:0] sx, sy, sz;
   always_comb begin
      if (sm4_ff.op == trpk_pkg::OP_FORWARD) begin
         sx = 64'(sm4_ff.x) + dx_ff;
         sy = 64'(sm4_ff.y) + dy_ff;
         sz = 64'(sm4_ff.z) + dz2_ff;
      end else begin
         sx = 64'(sm4_ff.x) - dx_ff;
         sy = 64'(sm4_ff.y) - dy_ff;
         sz = 64'(sm4_ff.z) - dz2_ff;
      end
   end

   logic rv_ff;
   logic signed [31:0] ox_ff, oy_ff, oz_ff;
   trpk_pkg::side_type so_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else begin
         rv_ff <= vm_ff[3];
      end
      ox_ff <= sat32(sx);
      oy_ff <= sat32(sy);
      oz_ff <= sat32(sz);
      so_ff <= sm4_ff;
   end

   assign rsp_valid = rv_ff;
   assign rsp_out_x = ox_ff;
   assign rsp_out_y = oy_ff;
   assign rsp_out_z = oz_ff;
   assign rsp_out_a = so_ff.a;
   assign rsp_out_b = so_ff.b;
   assign rsp_out_c = so_ff.c;
   assign rsp_out_u = so_ff.u;
   assign rsp_out_v = so_ff.v;
   assign rsp_out_w = so_ff.w;
endmodule

@@ hdl/trpk_cell.sv @@
// One CORDIC rotation cell: rotates both angle vectors by one step and registers.
`timescale 1ns / 1ps
module trpk_cell #(
   parameter int STAGE = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 vld_i,
   input  logic signed [33:0]   xb_i,
   input  logic signed [33:0]   yb_i,
   input  logic signed [24:0]   zb_i,
   input  logic signed [33:0]   xc_i,
   input  logic signed [33:0]   yc_i,
   input  logic signed [24:0]   zc_i,
   input  trpk_pkg::side_type   side_i,
   output logic                 vld_o,
   output logic signed [33:0]   xb_o,
   output logic signed [33:0]   yb_o,
   output logic signed [24:0]   zb_o,
   output logic signed [33:0]   xc_o,
   output logic signed [33:0]   yc_o,
   output logic signed [24:0]   zc_o,
   output trpk_pkg::side_type   side_o
);
   localparam logic [5:0] IDX = 6'(STAGE);

   logic signed [24:0] ang;
   logic signed [33:0] xb_in, yb_in, xc_in, yc_in;
   logic signed [24:0] zb_in, zc_in;
   logic vld_ff;
   logic signed [33:0] xb_ff, yb_ff, xc_ff, yc_ff;
   logic signed [24:0] zb_ff, zc_ff;
   trpk_pkg::side_type side_ff;

   // Rotation step; direction follows the sign of the residual angle.
   always_comb begin
      ang = 25'(trpk_pkg::arc_tab(IDX));
      if (zb_i >= 0) begin
         xb_in = xb_i - (yb_i >>> STAGE);
         yb_in = yb_i + (xb_i >>> STAGE);
         zb_in = zb_i - ang;
      end else begin
         xb_in = xb_i + (yb_i >>> STAGE);
         yb_in = yb_i - (xb_i >>> STAGE);
         zb_in = zb_i + ang;
      end
      if (zc_i >= 0) begin
         xc_in = xc_i - (yc_i >>> STAGE);
         yc_in = yc_i + (xc_i >>> STAGE);
         zc_in = zc_i - ang;
      end else begin
         xc_in = xc_i + (yc_i >>> STAGE);
         yc_in = yc_i - (xc_i >>> STAGE);
         zc_in = zc_i + ang;
      end
   end

   // Valid bit is control state; the rest is payload.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_i;
      end
      xb_ff   <= xb_in;
      yb_ff   <= yb_in;
      zb_ff   <= zb_in;
      xc_ff   <= xc_in;
      yc_ff   <= yc_in;
      zc_ff   <= zc_in;
      side_ff <= side_i;
   end

   assign vld_o  = vld_ff;
   assign xb_o   = xb_ff;
   assign yb_o   = yb_ff;
   assign zb_o   = zb_ff;
   assign xc_o   = xc_ff;
   assign yc_o   = yc_ff;
   assign zc_o   = zc_ff;
   assign side_o = side_ff;
endmodule

@@ hdl/trpk_reduce.sv @@
// Angle reduction stages: modulo 360 and split into quadrant and rest.
`timescale 1ns / 1ps
module trpk_reduce (
   input  logic                clock,
   input  logic signed [31:0]  ang_i,
   output logic [1:0]          quad_o,
   output logic signed [24:0]  rest_o
);
   // Reduction is a registered pipeline: the quotient by 360 through a reciprocal
   // multiply, then a correcting subtract and the quadrant split.
   // The reciprocal is rounded down, so the quotient estimate may be low by one.
   localparam logic [33:0] RECIP = 34'd11650; // floor(2^38 / 23592960)

   logic signed [31:0] ang_ff;
   logic [31:0]        mag;
   logic [63:0]        prod;
   logic [7:0]         qest_in, qest_ff;
   logic signed [31:0] ang2_ff;
   logic signed [33:0] r0;
   logic signed [33:0] r1;
   logic [1:0]         quad_in;
   logic signed [24:0] rest_in;
   logic [1:0]         quad_ff;
   logic signed [24:0] rest_ff;

   // Floor quotient of the angle by a turn, computed on the offset value.
   always_comb begin
      mag     = ang_i ^ 32'h8000_0000; // ang + 2^31, unsigned
      prod    = 64'(mag) * 64'(RECIP);
      qest_in = prod[45:38];
   end

   always_ff @(posedge clock) begin
      qest_ff <= qest_in;
      ang2_ff <= ang_i;
   end

   // Remainder of (ang + 2^31), then remove the offset's own remainder.
   always_comb begin
      r0 = 34'({1'b0, ang2_ff ^ 32'h8000_0000})
           - 34'(qest_ff) * 34'(trpk_pkg::TURN_Q16);
      if (r0 >= 34'(trpk_pkg::TURN_Q16)) r0 = r0 - 34'(trpk_pkg::TURN_Q16);
      if (r0 >= 34'(trpk_pkg::TURN_Q16)) r0 = r0 - 34'(trpk_pkg::TURN_Q16);
      // 2^31 mod 23592960 is 2^31 - 91 * 23592960 = 524288.
      r1 = r0 - 34'sd524288;
      if (r1 < 0) r1 = r1 + 34'(trpk_pkg::TURN_Q16);
      if (r1 >= 34'sd17694720) begin
         quad_in = 2'd3;
         rest_in = 25'(r1 - 34'sd17694720);
      end else if (r1 >= 34'sd11796480) begin
         quad_in = 2'd2;
         rest_in = 25'(r1 - 34'sd11796480);
      end else if (r1 >= 34'(trpk_pkg::QUARTER_Q16)) begin
         quad_in = 2'd1;
         rest_in = 25'(r1 - 34'(trpk_pkg::QUARTER_Q16));
      end else begin
         quad_in = 2'd0;
         rest_in = 25'(r1);
      end
   end

   always_ff @(posedge clock) begin
      quad_ff <= quad_in;
      rest_ff <= rest_in;
   end

   assign quad_o = quad_ff;
   assign rest_o = rest_ff;
endmodule

@@ hdl/trpk_checker.sv @@
// Port-level checker for the pivot kinematics unit and its bind.
`timescale 1ns / 1ps
module trpk_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input logic signed [31:0] req_rot_a,
   input logic signed [31:0] rsp_out_a
);
   // The unit never refuses a request.
   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");
   // A reset cycle clears rsp_valid, so no result follows it.
   a_rsp_after_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response during reset");
   // The A axis passes through to rsp_out_a unchanged, checked against its request.
   a_pass_a: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##23 (rsp_valid && rsp_out_a == $past(req_rot_a, 23)))
      else $error("A axis mismatch");
endmodule

bind tilt_rotary_pivot_kinematics_unit trpk_checker u_trpk_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .req_rot_a(req_rot_a), .rsp_out_a(rsp_out_a)
);

@@ tb/tilt_rotary_pivot_kinematics_unit_tb.sv @@
// Testbench for the pivot kinematics unit: random and directed requests checked by a scoreboard.
`timescale 1ns / 1ps
module tilt_rotary_pivot_kinematics_unit_tb;

   localparam int STAGES = 16;
   localparam int LATENCY = STAGES + 7;
   localparam int LIMIT = 200000;

   typedef struct packed {
      logic signed [31:0] x, y, z, a, b, c, u, v, w;
   } pose_type;

   // Angle reference table, atan(2^-i) in Q16.16 degrees.
   localparam longint ARC [0:15] = '{2949120, 1740967, 919879, 466945, 234379,
      117304, 58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};

   // Holds expected poses and compares them with the block output.
   class pose_scoreboard;
      pose_type pending[$];
      longint pivot_len = trpk_pkg::PIVOT_RESET;
      int mismatches = 0;

      function automatic longint mul_q30(longint p, longint q);
         return (p * q + 64'sd536870912) >>> 30;
      endfunction

      function automatic void sin_cos(longint ang, output longint sn, output longint cs);
         longint r, q, x, y, z, nx, ny;
         r = ang % 23592960;
         if (r < 0) r += 23592960;
         q = r / 5898240;
         z = r - q * 5898240;
         x = 652032874;
         y = 0;
         for (int i = 0; i < STAGES; i++) begin
            if (z >= 0) begin
               nx = x - (y >>> i); ny = y + (x >>> i); z -= ARC[i];
            end else begin
               nx = x + (y >>> i); ny = y - (x >>> i); z += ARC[i];
            end
            x = nx; y = ny;
         end
         case (q)
            0: begin cs = x; sn = y; end
            1: begin cs = -y; sn = x; end
            2: begin cs = -x; sn = -y; end
            default: begin cs = y; sn = -x; end
         endcase
      endfunction

      function automatic logic signed [31:0] clamp32(longint v);
         if (v > 64'sd2147483647) return 32'sh7fffffff;
         if (v < -64'sd2147483648) return 32'sh80000000;
         return v[31:0];
      endfunction

      // Notes an accepted request and predicts its pose.
      function automatic void note_request(logic op, pose_type in);
         longint sb, cb, sc, cc, lsb, dx, dy, dz;
         pose_type e;
         sin_cos(longint'(in.b), sb, cb);
         sin_cos(longint'(in.c), sc, cc);
         lsb = mul_q30(pivot_len, sb);
         dx = -mul_q30(lsb, sc);
         dy = mul_q30(lsb, cc);
         dz = pivot_len - mul_q30(pivot_len, cb);
         e = in;
         if (op == trpk_pkg::OP_FORWARD) begin
            e.x = clamp32(longint'(in.x) + dx);
            e.y = clamp32(longint'(in.y) + dy);
            e.z = clamp32(longint'(in.z) + dz);
         end else begin
            e.x = clamp32(longint'(in.x) - dx);
            e.y = clamp32(longint'(in.y) - dy);
            e.z = clamp32(longint'(in.z) - dz);
         end
         pending.push_back(e);
      endfunction

      // Checks one result against the oldest prediction.
      function automatic void check_result(pose_type got);
         pose_type e;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected result %h", got);
            return;
         end
         e = pending.pop_front();
         if (got !== e) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Mismatch: expected %h actual %h", e, got);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic req_operation = 0;
   pose_type req = '0;
   logic csr_we = 0;
   logic [30:0] csr_wdata = '0;
   logic rsp_valid;
   pose_type rsp;
   pose_scoreboard board;
   int cycles = 0;
   bit quiet = 0;

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   tilt_rotary_pivot_kinematics_unit #(.CORDIC_STAGES(STAGES)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_operation(req_operation),
      .req_lin_x(req.x), .req_lin_y(req.y), .req_lin_z(req.z),
      .req_rot_a(req.a), .req_tilt_b(req.b), .req_spin_c(req.c),
      .req_aux_u(req.u), .req_aux_v(req.v), .req_aux_w(req.w),
      .csr_we(csr_we), .csr_wdata(csr_wdata), .rsp_valid(rsp_valid),
      .rsp_out_x(rsp.x), .rsp_out_y(rsp.y), .rsp_out_z(rsp.z),
      .rsp_out_a(rsp.a), .rsp_out_b(rsp.b), .rsp_out_c(rsp.c),
      .rsp_out_u(rsp.u), .rsp_out_v(rsp.v), .rsp_out_w(rsp.w));

   initial board = new();

   // Result monitor and run limit.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_valid) board.check_result(rsp);
      if (cycles > LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Drives one request, holding start until it is taken.
   task automatic send_request(logic op, pose_type p);
      while (!quiet && $urandom_range(99) < 6) begin
         start <= 0;
         @(posedge clock);
      end
      start <= 1;
      req_operation <= op;
      req <= p;
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_request(op, p);
   endtask

   // Waits until every predicted pose has come back, then lets the pipe drain.
   task automatic drain();
      start <= 0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   task automatic write_pivot(logic [30:0] len);
      csr_we <= 1;
      csr_wdata <= len;
      @(posedge clock);
      csr_we <= 0;
      board.pivot_len = len;
   endtask

   function automatic logic signed [31:0] rand_angle();
      case ($urandom_range(3))
         0: return $urandom_range(23592959);
         1: return -$signed({1'b0, 31'($urandom_range(23592960 * 4))});
         default: return $urandom;
      endcase
   endfunction

   function automatic pose_type rand_pose();
      pose_type p;
      p.x = $urandom; p.y = $urandom; p.z = $urandom;
      if ($urandom_range(1)) begin
         p.x = $signed(p.x) >>> 8; p.y = $signed(p.y) >>> 8; p.z = $signed(p.z) >>> 8;
      end
      p.a = $urandom; p.b = rand_angle(); p.c = rand_angle();
      p.u = $urandom; p.v = $urandom; p.w = $urandom;
      return p;
   endfunction

   initial begin
      pose_type p;
      logic signed [31:0] edges [0:7];
      logic [30:0] lens [0:4];
      edges = '{32'sh80000000, 32'sh7fffffff, 0, 23592960, 5898240, 11796480,
         -5898240, 17694720};
      lens = '{31'd0, 31'h7fffffff, 31'd16384000, 31'd65536, 31'd123456789};
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: angle extremes, quadrant boundaries, both operations, saturation.
      for (int i = 0; i < 8; i++) begin
         p = '{x: edges[7 - i], y: edges[i], z: edges[(i + 3) % 8], a: edges[i],
            b: edges[i], c: edges[(i + 2) % 8], u: edges[i], v: -1, w: edges[7 - i]};
         send_request(i[0] ? trpk_pkg::OP_INVERSE : trpk_pkg::OP_FORWARD, p);
      end
      drain();
      write_pivot(31'h7fffffff);
      for (int i = 0; i < 8; i++) begin
         p = '{x: edges[i], y: edges[7 - i], z: edges[i], a: 0, b: edges[(i + 4) % 8],
            c: edges[i], u: 0, v: edges[i], w: 0};
         send_request(i[1] ? trpk_pkg::OP_INVERSE : trpk_pkg::OP_FORWARD, p);
      end

      // Random phases across several pivot lengths.
      for (int ph = 0; ph < 5; ph++) begin
         drain();
         write_pivot(ph == 4 ? 31'($urandom) : lens[ph]);
         quiet = (ph == 2);
         for (int n = 0; n < 90; n++) send_request($urandom_range(1), rand_pose());
      end
      quiet = 0;
      drain();
      if (board.mismatches == 0 && board.pending.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule
